// ----- design/dgvb_pkg.sv -----
// shared widths, codes and constants of the vertex blend block
package dgvb_pkg;

    localparam int NODE_COUNT    = 1024;
    localparam int FRACTION_BITS = 16;
    localparam int UNIT_BITS     = 16;
    localparam int IDX_W         = 10;
    localparam int PART_W        = 3;
    localparam int VAL_W         = 32;
    localparam int W_W           = 17;
    localparam int NRM_W         = 18;
    localparam int WEIGHT_ONE    = 65536;
    localparam int NODE_AW       = $clog2(NODE_COUNT);
    localparam int ROW_COUNT     = 5;
    localparam int ROW_W         = 3 * VAL_W;

    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_INFLUENCE = 1'b1;

    localparam logic [PART_W-1:0] PART_POSITION    = 3'd3;
    localparam logic [PART_W-1:0] PART_TRANSLATION = 3'd4;

endpackage

// ----- design/dgvb_if.sv -----
// item and result channels of the vertex blend block
interface dgvb_item_if
    import dgvb_pkg::*;
    ;
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [IDX_W-1:0]        node_index;
    logic [PART_W-1:0]       part;
    logic signed [VAL_W-1:0] val_x;
    logic signed [VAL_W-1:0] val_y;
    logic signed [VAL_W-1:0] val_z;
    logic signed [VAL_W-1:0] norm_x;
    logic signed [VAL_W-1:0] norm_y;
    logic signed [VAL_W-1:0] norm_z;
    logic [W_W-1:0]          influence_weight;
    logic                    last_influence;

    modport source
    (
        output valid, operation, node_index, part, val_x, val_y, val_z,
               norm_x, norm_y, norm_z, influence_weight, last_influence,
        input  ready
    );
    modport sink
    (
        input  valid, operation, node_index, part, val_x, val_y, val_z,
               norm_x, norm_y, norm_z, influence_weight, last_influence,
        output ready
    );
endinterface

interface dgvb_result_if
    import dgvb_pkg::*;
    ;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;
    logic signed [VAL_W-1:0] out_z;
    logic signed [NRM_W-1:0] out_nx;
    logic signed [NRM_W-1:0] out_ny;
    logic signed [NRM_W-1:0] out_nz;

    modport source
    (
        output valid, out_x, out_y, out_z, out_nx, out_ny, out_nz,
        input  ready
    );
    modport sink
    (
        input  valid, out_x, out_y, out_z, out_nx, out_ny, out_nz,
        output ready
    );
endinterface

// ----- design/deform_graph_vertex_blend.sv -----
// deformation graph vertex blend: node table, shared multiplier, serial divider and root
//
// Node data lives in one synchronous memory with five 96-bit rows per node (three matrix
// rows, position, translation). A load item writes one row. An influence item reads its
// five rows, then runs all products through a single registered 33x33 multiplier for the
// position term, cofactors and determinant, and for each normal component when the
// determinant is nonzero (the quotient comes from a one-bit-per-cycle divider).
// An influence marked last adds the output pass: the normalizing shift (one bit a cycle),
// a 32-step square root and three 48-step divides. The finished result sits in an output
// register, so the next item is taken while it waits; only a second result stalls on it.
module deform_graph_vertex_blend
    import dgvb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    dgvb_item_if.sink    items,
    dgvb_result_if.source results
);

    localparam int MUL_W   = 66;
    localparam int ACC_W   = 64;
    localparam int DIV_W   = 48;
    localparam int CNT_W   = 6;
    localparam int MEM_AW  = NODE_AW + PART_W;
    localparam int MEM_DEPTH = NODE_COUNT * (2 ** PART_W);

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_READ     = 5'd1;
    localparam logic [4:0] ST_POS_MUL  = 5'd2;
    localparam logic [4:0] ST_POS_ACC  = 5'd3;
    localparam logic [4:0] ST_POS_WMUL = 5'd4;
    localparam logic [4:0] ST_POS_WACC = 5'd5;
    localparam logic [4:0] ST_COF_MUL  = 5'd6;
    localparam logic [4:0] ST_COF_ACC  = 5'd7;
    localparam logic [4:0] ST_DET_MUL  = 5'd8;
    localparam logic [4:0] ST_DET_ACC  = 5'd9;
    localparam logic [4:0] ST_NRM_MUL  = 5'd10;
    localparam logic [4:0] ST_NRM_ACC  = 5'd11;
    localparam logic [4:0] ST_NRM_DIV  = 5'd12;
    localparam logic [4:0] ST_NRM_WMUL = 5'd13;
    localparam logic [4:0] ST_NRM_WACC = 5'd14;
    localparam logic [4:0] ST_CHECK    = 5'd15;
    localparam logic [4:0] ST_EMIT     = 5'd16;
    localparam logic [4:0] ST_SCAN     = 5'd17;
    localparam logic [4:0] ST_SQ_MUL   = 5'd18;
    localparam logic [4:0] ST_SQ_ACC   = 5'd19;
    localparam logic [4:0] ST_SQRT     = 5'd20;
    localparam logic [4:0] ST_UDIV     = 5'd21;
    localparam logic [4:0] ST_OUT      = 5'd22;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (UNIT_BITS - 1));

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            return 32'sh80000000;
        else
            return x[VAL_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        return s[ACC_W-1:0];
    endfunction

    function automatic logic [1:0] nxt3(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    function automatic logic [DIV_W-1:0] unit_num(input logic [ACC_W-1:0] m,
                                                  input logic [VAL_W-1:0] len);
        return DIV_W'({m[29:0], {UNIT_BITS{1'b0}}}) + DIV_W'(len >> 1);
    endfunction

    // control
    logic [4:0]       state_reg;
    logic [1:0]       i_reg;
    logic [1:0]       j_reg;
    logic             k_reg;
    logic [CNT_W-1:0] cnt_reg;

    // captured item
    logic [IDX_W-1:0]        idx_reg;
    logic                    last_reg;
    logic [W_W-1:0]          w_reg;
    logic signed [VAL_W-1:0] v_reg [3];
    logic signed [VAL_W-1:0] n_reg [3];

    // node data and working values
    logic signed [VAL_W-1:0] a_reg   [3][3];
    logic signed [VAL_W-1:0] cof_reg [3][3];
    logic signed [VAL_W-1:0] g_reg   [3];
    logic signed [VAL_W-1:0] t_reg   [3];
    logic signed [VAL_W:0]   d_reg   [3];
    logic signed [ACC_W-1:0] det_reg;
    logic signed [ACC_W-1:0] sum_reg;
    logic signed [VAL_W-1:0] term_reg;
    logic signed [ACC_W-1:0] pacc_reg [3];
    logic signed [ACC_W-1:0] nacc_reg [3];
    logic [ACC_W-1:0]        mag_reg  [3];

    // root and divider
    logic [ACC_W-1:0] sq_x_reg;
    logic [ACC_W-1:0] sq_r_reg;
    logic [ACC_W-1:0] sq_bit_reg;
    logic [VAL_W-1:0] len_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] den_reg;
    logic             div_neg_reg;

    // results
    logic signed [VAL_W-1:0] res_pos_reg [3];
    logic signed [NRM_W-1:0] res_nrm_reg [3];
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_pos_reg [3];
    logic signed [NRM_W-1:0] out_nrm_reg [3];

    // memory
    logic [ROW_W-1:0]  node_mem [MEM_DEPTH];
    logic [ROW_W-1:0]  rd_data_reg;
    logic [MEM_AW-1:0] rd_addr;
    logic [MEM_AW-1:0] wr_addr;
    logic              wr_en;

    logic                    in_xfer;
    logic                    in_idx_ok;
    logic signed [VAL_W:0]   mul_a;
    logic signed [VAL_W:0]   mul_b;
    logic signed [MUL_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] fx_prod;
    logic signed [ACC_W-1:0] raw_prod;
    logic signed [ACC_W-1:0] sum_next;
    logic signed [VAL_W-1:0] cn_val;
    logic [VAL_W-1:0]        cn_abs;
    logic signed [ACC_W-1:0] det_abs;
    logic [DIV_W:0]          div_trial;
    logic [DIV_W:0]          div_diff;
    logic                    div_ge;
    logic [DIV_W-1:0]        rem_step;
    logic [DIV_W-1:0]        quo_step;
    logic                    div_last;
    logic signed [ACC_W-1:0] q_signed;
    logic [NRM_W-1:0]        u_mag;
    logic [ACC_W-1:0]        big;
    logic [ACC_W-1:0]        sq_rb;
    logic                    sq_ge;
    logic [ACC_W-1:0]        sq_r_next;
    logic [2:0]              row;

    // handshake
    assign items.ready = (state_reg == ST_IDLE);
    assign in_xfer     = items.valid && items.ready;
    assign in_idx_ok   = ({1'b0, items.node_index} < (IDX_W + 1)'(NODE_COUNT));

    assign results.valid  = out_valid_reg;
    assign results.out_x  = out_pos_reg[0];
    assign results.out_y  = out_pos_reg[1];
    assign results.out_z  = out_pos_reg[2];
    assign results.out_nx = out_nrm_reg[0];
    assign results.out_ny = out_nrm_reg[1];
    assign results.out_nz = out_nrm_reg[2];

    // node table: load writes a row, influence reads its rows in turn
    assign wr_en   = in_xfer && (items.operation == OP_LOAD) && in_idx_ok
                     && (items.part < PART_W'(ROW_COUNT));
    assign wr_addr = {items.node_index[NODE_AW-1:0], items.part};
    assign rd_addr = {idx_reg[NODE_AW-1:0], cnt_reg[PART_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            node_mem[wr_addr] <= {items.val_x, items.val_y, items.val_z};
        rd_data_reg <= node_mem[rd_addr];
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_POS_MUL:
            begin
                mul_a = (VAL_W + 1)'(a_reg[i_reg][j_reg]);
                mul_b = d_reg[j_reg];
            end
            ST_POS_WMUL, ST_NRM_WMUL:
            begin
                mul_a = signed'((VAL_W + 1)'(w_reg));
                mul_b = (VAL_W + 1)'(term_reg);
            end
            ST_COF_MUL:
            begin
                if (!k_reg)
                begin
                    mul_a = (VAL_W + 1)'(a_reg[nxt3(i_reg)][nxt3(j_reg)]);
                    mul_b = (VAL_W + 1)'(a_reg[nxt3(nxt3(i_reg))][nxt3(nxt3(j_reg))]);
                end
                else
                begin
                    mul_a = (VAL_W + 1)'(a_reg[nxt3(i_reg)][nxt3(nxt3(j_reg))]);
                    mul_b = (VAL_W + 1)'(a_reg[nxt3(nxt3(i_reg))][nxt3(j_reg)]);
                end
            end
            ST_DET_MUL:
            begin
                mul_a = (VAL_W + 1)'(a_reg[0][j_reg]);
                mul_b = (VAL_W + 1)'(cof_reg[0][j_reg]);
            end
            ST_NRM_MUL:
            begin
                mul_a = (VAL_W + 1)'(cof_reg[i_reg][j_reg]);
                mul_b = (VAL_W + 1)'(n_reg[j_reg]);
            end
            ST_SQ_MUL:
            begin
                mul_a = signed'({3'b000, mag_reg[i_reg][29:0]});
                mul_b = signed'({3'b000, mag_reg[i_reg][29:0]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign fx_prod  = ACC_W'(prod_reg >>> FRACTION_BITS);
    assign raw_prod = ACC_W'(prod_reg);

    // running sum of products
    always_comb
    begin
        case (state_reg)
            ST_POS_ACC:
                sum_next = ((j_reg == 2'd0) ? (ACC_W'(g_reg[i_reg]) + ACC_W'(t_reg[i_reg]))
                                            : sum_reg) + fx_prod;
            ST_DET_ACC, ST_NRM_ACC:
                sum_next = ((j_reg == 2'd0) ? '0 : sum_reg) + fx_prod;
            ST_SQ_ACC:
                sum_next = ((i_reg == 2'd0) ? '0 : sum_reg) + raw_prod;
            default:
                sum_next = sum_reg - fx_prod;
        endcase
    end

    assign cn_val  = sat32(sum_next);
    assign cn_abs  = cn_val[VAL_W-1] ? VAL_W'(-cn_val) : VAL_W'(cn_val);
    assign det_abs = det_reg[ACC_W-1] ? -det_reg : det_reg;

    // restoring divider step, one quotient bit a cycle
    assign div_trial = {rem_reg, quo_reg[DIV_W-1]};
    assign div_diff  = div_trial - {1'b0, den_reg};
    assign div_ge    = (div_trial >= {1'b0, den_reg});
    assign rem_step  = div_ge ? div_diff[DIV_W-1:0] : div_trial[DIV_W-1:0];
    assign quo_step  = {quo_reg[DIV_W-2:0], div_ge};
    assign div_last  = (cnt_reg == CNT_W'(DIV_W - 1));
    assign q_signed  = div_neg_reg ? -signed'(ACC_W'(quo_step)) : signed'(ACC_W'(quo_step));
    assign u_mag     = quo_step[NRM_W-1:0];

    // square root step, two radicand bits a cycle
    assign sq_rb     = sq_r_reg + sq_bit_reg;
    assign sq_ge     = (sq_x_reg >= sq_rb);
    assign sq_r_next = sq_ge ? ((sq_r_reg >> 1) + sq_bit_reg) : (sq_r_reg >> 1);

    // largest normal magnitude
    always_comb
    begin
        big = mag_reg[0];
        if (mag_reg[1] > big)
            big = mag_reg[1];
        if (mag_reg[2] > big)
            big = mag_reg[2];
    end

    assign row = cnt_reg[2:0] - 3'd1;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                pacc_reg[k] <= '0;
                nacc_reg[k] <= '0;
            end
        end
        else
        begin
            if (results.valid && results.ready && (state_reg != ST_OUT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer && (items.operation == OP_INFLUENCE))
                    begin
                        idx_reg  <= items.node_index;
                        last_reg <= items.last_influence;
                        w_reg    <= (items.influence_weight > W_W'(WEIGHT_ONE))
                                    ? W_W'(WEIGHT_ONE) : items.influence_weight;
                        v_reg[0] <= items.val_x;
                        v_reg[1] <= items.val_y;
                        v_reg[2] <= items.val_z;
                        n_reg[0] <= items.norm_x;
                        n_reg[1] <= items.norm_y;
                        n_reg[2] <= items.norm_z;
                        cnt_reg  <= '0;
                        state_reg <= in_idx_ok ? ST_READ : ST_CHECK;
                    end
                end

                ST_READ:
                begin
                    if (cnt_reg != '0)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            case (row)
                                3'd0, 3'd1, 3'd2:
                                    a_reg[row[1:0]][k] <= rd_data_reg[ROW_W-1-VAL_W*k -: VAL_W];
                                PART_POSITION:
                                begin
                                    g_reg[k] <= rd_data_reg[ROW_W-1-VAL_W*k -: VAL_W];
                                    d_reg[k] <= (VAL_W + 1)'(v_reg[k])
                                        - (VAL_W + 1)'(signed'(rd_data_reg[ROW_W-1-VAL_W*k -: VAL_W]));
                                end
                                PART_TRANSLATION:
                                    t_reg[k] <= rd_data_reg[ROW_W-1-VAL_W*k -: VAL_W];
                                default:
                                    ;
                            endcase
                        end
                    end
                    if (cnt_reg == CNT_W'(ROW_COUNT))
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= ST_POS_MUL;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end

                ST_POS_MUL:
                    state_reg <= ST_POS_ACC;

                // a(v-g)+g+t, one product a visit
                ST_POS_ACC:
                begin
                    sum_reg <= sum_next;
                    if (j_reg == 2'd2)
                    begin
                        term_reg  <= sat32(sum_next);
                        j_reg     <= '0;
                        state_reg <= ST_POS_WMUL;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_POS_MUL;
                    end
                end

                ST_POS_WMUL:
                    state_reg <= ST_POS_WACC;

                ST_POS_WACC:
                begin
                    pacc_reg[i_reg] <= sat_add(pacc_reg[i_reg], raw_prod);
                    if (i_reg == 2'd2)
                    begin
                        i_reg     <= '0;
                        k_reg     <= 1'b0;
                        state_reg <= ST_COF_MUL;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_POS_MUL;
                    end
                end

                ST_COF_MUL:
                    state_reg <= ST_COF_ACC;

                // cofactor as difference of two floored products
                ST_COF_ACC:
                begin
                    if (!k_reg)
                    begin
                        sum_reg   <= fx_prod;
                        k_reg     <= 1'b1;
                        state_reg <= ST_COF_MUL;
                    end
                    else
                    begin
                        cof_reg[i_reg][j_reg] <= sat32(sum_next);
                        k_reg <= 1'b0;
                        if (j_reg == 2'd2)
                        begin
                            j_reg <= '0;
                            if (i_reg == 2'd2)
                            begin
                                i_reg     <= '0;
                                state_reg <= ST_DET_MUL;
                            end
                            else
                            begin
                                i_reg     <= i_reg + 1'b1;
                                state_reg <= ST_COF_MUL;
                            end
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= ST_COF_MUL;
                        end
                    end
                end

                ST_DET_MUL:
                    state_reg <= ST_DET_ACC;

                ST_DET_ACC:
                begin
                    sum_reg <= sum_next;
                    if (j_reg == 2'd2)
                    begin
                        det_reg   <= sum_next;
                        j_reg     <= '0;
                        i_reg     <= '0;
                        state_reg <= (sum_next == '0) ? ST_CHECK : ST_NRM_MUL;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_DET_MUL;
                    end
                end

                ST_NRM_MUL:
                    state_reg <= ST_NRM_ACC;

                // cofactor row times normal, then divide by the determinant
                ST_NRM_ACC:
                begin
                    sum_reg <= sum_next;
                    if (j_reg == 2'd2)
                    begin
                        quo_reg     <= DIV_W'({cn_abs, {FRACTION_BITS{1'b0}}});
                        den_reg     <= det_abs[DIV_W-1:0];
                        rem_reg     <= '0;
                        div_neg_reg <= cn_val[VAL_W-1] ^ det_reg[ACC_W-1];
                        cnt_reg     <= '0;
                        j_reg       <= '0;
                        state_reg   <= ST_NRM_DIV;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_NRM_MUL;
                    end
                end

                ST_NRM_DIV:
                begin
                    rem_reg <= rem_step;
                    quo_reg <= quo_step;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (div_last)
                    begin
                        term_reg  <= sat32(q_signed);
                        state_reg <= ST_NRM_WMUL;
                    end
                end

                ST_NRM_WMUL:
                    state_reg <= ST_NRM_WACC;

                ST_NRM_WACC:
                begin
                    nacc_reg[i_reg] <= sat_add(nacc_reg[i_reg], raw_prod);
                    if (i_reg == 2'd2)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_CHECK;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_NRM_MUL;
                    end
                end

                ST_CHECK:
                    state_reg <= last_reg ? ST_EMIT : ST_IDLE;

                // rounded position and normal magnitudes
                ST_EMIT:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        res_pos_reg[k] <= sat32(sat_add(pacc_reg[k], ROUND_HALF) >>> UNIT_BITS);
                        mag_reg[k]     <= nacc_reg[k][ACC_W-1] ? ACC_W'(-nacc_reg[k])
                                                               : ACC_W'(nacc_reg[k]);
                    end
                    state_reg <= ST_SCAN;
                end

                // bring the largest magnitude into [2^29, 2^30)
                ST_SCAN:
                begin
                    if (big == '0)
                    begin
                        for (int k = 0; k < 3; k++)
                            res_nrm_reg[k] <= '0;
                        state_reg <= ST_OUT;
                    end
                    else if (|big[ACC_W-1:30])
                    begin
                        for (int k = 0; k < 3; k++)
                            mag_reg[k] <= mag_reg[k] >> 1;
                    end
                    else if (!(|big[ACC_W-1:29]))
                    begin
                        for (int k = 0; k < 3; k++)
                            mag_reg[k] <= mag_reg[k] << 1;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_SQ_MUL;
                    end
                end

                ST_SQ_MUL:
                    state_reg <= ST_SQ_ACC;

                ST_SQ_ACC:
                begin
                    sum_reg <= sum_next;
                    if (i_reg == 2'd2)
                    begin
                        sq_x_reg   <= ACC_W'(sum_next);
                        sq_r_reg   <= '0;
                        sq_bit_reg <= ACC_W'(64'd1 << 62);
                        state_reg  <= ST_SQRT;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_SQ_MUL;
                    end
                end

                ST_SQRT:
                begin
                    if (sq_ge)
                        sq_x_reg <= sq_x_reg - sq_rb;
                    sq_r_reg   <= sq_r_next;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg == ACC_W'(1))
                    begin
                        len_reg     <= sq_r_next[VAL_W-1:0];
                        quo_reg     <= unit_num(mag_reg[0], sq_r_next[VAL_W-1:0]);
                        den_reg     <= DIV_W'(sq_r_next[VAL_W-1:0]);
                        rem_reg     <= '0;
                        div_neg_reg <= nacc_reg[0][ACC_W-1];
                        cnt_reg     <= '0;
                        i_reg       <= '0;
                        state_reg   <= ST_UDIV;
                    end
                end

                // unit components, rounded quotient of magnitude by length
                ST_UDIV:
                begin
                    rem_reg <= rem_step;
                    quo_reg <= quo_step;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (div_last)
                    begin
                        res_nrm_reg[i_reg] <= div_neg_reg ? NRM_W'(-u_mag) : NRM_W'(u_mag);
                        if (i_reg == 2'd2)
                            state_reg <= ST_OUT;
                        else
                        begin
                            quo_reg     <= unit_num(mag_reg[i_reg + 2'd1], len_reg);
                            den_reg     <= DIV_W'(len_reg);
                            rem_reg     <= '0;
                            div_neg_reg <= nacc_reg[i_reg + 2'd1][ACC_W-1];
                            cnt_reg     <= '0;
                            i_reg       <= i_reg + 1'b1;
                        end
                    end
                end

                // hand over to the output register and clear the sums
                ST_OUT:
                begin
                    if (!out_valid_reg || results.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        for (int k = 0; k < 3; k++)
                        begin
                            out_pos_reg[k] <= res_pos_reg[k];
                            out_nrm_reg[k] <= res_nrm_reg[k];
                            pacc_reg[k]    <= '0;
                            nacc_reg[k]    <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- design/dgvb_checker.sv -----
// port-level checks of the vertex blend block and their binding
module dgvb_checker
    import dgvb_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    in_operation,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [NRM_W-1:0] out_nx,
    input logic signed [NRM_W-1:0] out_ny,
    input logic signed [NRM_W-1:0] out_nz
);

    // a pending result stays until transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    // unit normal components stay within one
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_nx >= -18'sd65536) && (out_nx <= 18'sd65536)
                   && (out_ny >= -18'sd65536) && (out_ny <= 18'sd65536)
                   && (out_nz >= -18'sd65536) && (out_nz <= 18'sd65536))
        else $error("normal component out of range");

    // a load finishes in its own cycle
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_operation == OP_LOAD) |=> in_ready)
        else $error("load did not free the input");

    // an influence keeps the input busy
    a_infl_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_operation == OP_INFLUENCE) |=> !in_ready)
        else $error("input taken during influence work");

endmodule

bind deform_graph_vertex_blend dgvb_checker u_dgvb_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (items.valid),
    .in_ready     (items.ready),
    .in_operation (items.operation),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_nx       (results.out_nx),
    .out_ny       (results.out_ny),
    .out_nz       (results.out_nz)
);
